### hdl/bds_pkg.sv
// bds_pkg: types and constants shared by the baud divider search block.
// Used by bds_div and baud_divider_search; depends on nothing else.
package bds_pkg;

    localparam int BAUD_W   = 25;
    localparam int CLK_W    = 32;
    localparam int SBR_W    = 13;
    localparam int OSR_W    = 6;
    localparam int PROD_W   = BAUD_W + OSR_W;
    localparam int DIV_NUM_W = 34;
    localparam int DIV_DEN_W = 32;
    localparam int DIV_BITS_PER_CYCLE = 2;
    localparam int DIV_STEPS = DIV_NUM_W / DIV_BITS_PER_CYCLE;
    localparam int DIV_CNT_W = 5;
    localparam int SCALED_W = CLK_W + 7;
    localparam int LIMIT_W  = BAUD_W + 3;

    localparam logic [CLK_W-1:0] CLOCK_HZ_RESET = 32'd24000000;
    localparam logic [SBR_W-1:0] SBR_MAX        = 13'd8191;
    localparam logic [OSR_W-1:0] OSR_FIRST      = 6'd4;
    localparam logic [OSR_W-1:0] OSR_LAST       = 6'd32;
    localparam logic [6:0]       PCT_SCALE      = 7'd100;
    localparam logic [2:0]       TOL_PCT_LIMIT  = 3'd4;   // tolerance of 3 percent, plus one

    typedef enum logic [3:0] {
        S_IDLE,
        S_MUL1,
        S_DIV1_GO,
        S_DIV1_WAIT,
        S_MUL2,
        S_DIV2_GO,
        S_DIV2_WAIT,
        S_EVAL,
        S_SCALE,
        S_CHECK,
        S_DONE
    } bds_state_t;

endpackage

### hdl/bds_div.sv
// bds_div: unsigned restoring divider, two quotient bits per cycle.
// Depends on bds_pkg for widths and step count.
module bds_div import bds_pkg::*; (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 start,
    input  logic [DIV_NUM_W-1:0] num,
    input  logic [DIV_DEN_W-1:0] den,
    output logic                 done,
    output logic [DIV_NUM_W-1:0] quo
);

    logic                 busy_reg;
    logic                 done_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic [DIV_DEN_W-1:0] rem_reg;
    logic [DIV_DEN_W-1:0] rem_next;
    logic [DIV_NUM_W-1:0] quo_reg;
    logic [DIV_NUM_W-1:0] quo_next;
    logic [DIV_DEN_W-1:0] den_reg;

    // two dependent shift-compare-subtract steps
    always_comb begin
        logic [DIV_DEN_W:0]   t;
        logic [DIV_DEN_W-1:0] r;
        logic [DIV_NUM_W-1:0] q;
        r = rem_reg;
        q = quo_reg;
        for (int i = 0; i < DIV_BITS_PER_CYCLE; i++) begin
            t = {r, q[DIV_NUM_W-1]};
            q = {q[DIV_NUM_W-2:0], 1'b0};
            if (t >= {1'b0, den_reg}) begin
                t    = t - {1'b0, den_reg};
                q[0] = 1'b1;
            end
            r = t[DIV_DEN_W-1:0];
        end
        rem_next = r;
        quo_next = q;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == DIV_CNT_W'(DIV_STEPS - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            rem_reg <= '0;
            quo_reg <= num;
            den_reg <= den;
        end else if (busy_reg) begin
            rem_reg <= rem_next;
            quo_reg <= quo_next;
        end
    end

    assign done = done_reg;
    assign quo  = quo_reg;

endmodule

### hdl/baud_divider_search.sv
// baud_divider_search: picks the rate divisor and oversampling ratio for a line speed.
// Searches up to 29 ratios per beat (4 to 32), stopping early when a ratio yields a
// zero divisor. Handles one beat at a time, limited by the shared two-bit-per-cycle
// divider that runs twice per ratio.
// Reset: synchronous active-low aresetn; clock_hz returns to 24000000, no result pending.
// Depends on bds_pkg and bds_div.
module baud_divider_search import bds_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    // configuration write: clock_hz
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [31:0] cfg_data,
    // request stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [24:0] baud_rate, [31:25] zero
    // result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // [12:0] rate_divisor, [18:13] oversample_ratio, [23:19] zero
    output logic        m_tuser    // [0] found
);

    bds_state_t state_reg, state_next;

    logic [CLK_W-1:0]    clock_hz_reg;
    logic [BAUD_W-1:0]   baud_reg;
    logic [OSR_W-1:0]    osr_reg;
    logic [SBR_W-1:0]    sbr_reg;
    logic [PROD_W-1:0]   prod_reg;
    logic                tried_reg;
    logic [CLK_W-1:0]    best_err_reg;
    logic [SBR_W-1:0]    best_sbr_reg;
    logic [OSR_W-1:0]    best_osr_reg;
    logic [SCALED_W-1:0] scaled_reg;
    logic [LIMIT_W-1:0]  limit_reg;
    logic                ok_reg;

    logic                out_valid_reg;
    logic                out_found_reg;
    logic [SBR_W-1:0]    out_sbr_reg;
    logic [OSR_W-1:0]    out_osr_reg;

    logic                s_accept;
    logic                out_free;
    logic [BAUD_W-1:0]   mul_a;
    logic [PROD_W-1:0]   mul_p;
    logic                div_start;
    logic                div_done;
    logic [DIV_NUM_W-1:0] div_num;
    logic [DIV_DEN_W-1:0] div_den;
    logic [DIV_NUM_W-1:0] div_quo;
    logic [SBR_W-1:0]    sbr_clamped;
    logic [CLK_W-1:0]    actual;
    logic [CLK_W-1:0]    err;
    logic                take_best;

    assign cfg_ready = 1'b1;
    assign s_tready  = (state_reg == S_IDLE);
    assign s_accept  = s_tvalid && s_tready;
    assign out_free  = !out_valid_reg || m_tready;

    // configuration register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clock_hz_reg <= CLOCK_HZ_RESET;
        end else if (cfg_valid && cfg_ready) begin
            clock_hz_reg <= cfg_data;
        end
    end

    // shared multiplier: baud * osr for the divisor, sbr * osr for the check
    always_comb begin
        mul_a = (state_reg == S_MUL1) ? baud_reg : BAUD_W'(sbr_reg);
        mul_p = PROD_W'(mul_a) * PROD_W'(osr_reg);
    end

    // divider operands: round-to-nearest for sbr, plain floor for the actual rate
    always_comb begin
        if (state_reg == S_DIV1_GO) begin
            div_num = {1'b0, clock_hz_reg, 1'b0} + DIV_NUM_W'(prod_reg);
            div_den = DIV_DEN_W'({prod_reg, 1'b0});
        end else begin
            div_num = DIV_NUM_W'(clock_hz_reg);
            div_den = DIV_DEN_W'(prod_reg);
        end
    end

    bds_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .num     (div_num),
        .den     (div_den),
        .done    (div_done),
        .quo     (div_quo)
    );

    // clamp the divisor, measure the error of the achieved rate
    always_comb begin
        sbr_clamped = (div_quo > DIV_NUM_W'(SBR_MAX)) ? SBR_MAX : div_quo[SBR_W-1:0];
        actual      = div_quo[CLK_W-1:0];
        err         = (CLK_W'(baud_reg) > actual) ? (CLK_W'(baud_reg) - actual)
                                                  : (actual - CLK_W'(baud_reg));
        take_best   = !tried_reg || (err <= best_err_reg);
    end

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (s_accept) begin
                    state_next = (s_tdata[BAUD_W-1:0] == '0) ? S_SCALE : S_MUL1;
                end
            end
            S_MUL1:      state_next = S_DIV1_GO;
            S_DIV1_GO:   state_next = S_DIV1_WAIT;
            S_DIV1_WAIT: begin
                if (div_done) begin
                    // a zero divisor ends the search
                    state_next = (sbr_clamped == '0) ? S_SCALE : S_MUL2;
                end
            end
            S_MUL2:      state_next = S_DIV2_GO;
            S_DIV2_GO:   state_next = S_DIV2_WAIT;
            S_DIV2_WAIT: begin
                if (div_done) begin
                    state_next = S_EVAL;
                end
            end
            S_EVAL:      state_next = (osr_reg == OSR_LAST) ? S_SCALE : S_MUL1;
            S_SCALE:     state_next = S_CHECK;
            S_CHECK:     state_next = S_DONE;
            S_DONE: begin
                if (out_free) begin
                    state_next = S_IDLE;
                end
            end
            default:     state_next = S_IDLE;
        endcase
    end

    // state outputs
    always_comb begin
        div_start = (state_reg == S_DIV1_GO) || (state_reg == S_DIV2_GO);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // search datapath
    always_ff @(posedge aclk) begin
        unique case (state_reg)
            S_IDLE: begin
                if (s_accept) begin
                    baud_reg  <= s_tdata[BAUD_W-1:0];
                    osr_reg   <= OSR_FIRST;
                    tried_reg <= 1'b0;
                    best_err_reg <= '0;
                    best_sbr_reg <= '0;
                    best_osr_reg <= '0;
                end
            end
            S_MUL1, S_MUL2: begin
                prod_reg <= mul_p;
            end
            S_DIV1_WAIT: begin
                if (div_done) begin
                    sbr_reg <= sbr_clamped;
                end
            end
            S_EVAL: begin
                // ties go to the later, higher ratio
                if (take_best) begin
                    tried_reg    <= 1'b1;
                    best_err_reg <= err;
                    best_sbr_reg <= sbr_reg;
                    best_osr_reg <= osr_reg;
                end
                osr_reg <= osr_reg + 1'b1;
            end
            S_SCALE: begin
                // floor(err*100/baud) <= 3 holds exactly when err*100 < 4*baud
                scaled_reg <= SCALED_W'(best_err_reg) * SCALED_W'(PCT_SCALE);
                limit_reg  <= LIMIT_W'(baud_reg) * LIMIT_W'(TOL_PCT_LIMIT);
            end
            S_CHECK: begin
                ok_reg <= tried_reg && (scaled_reg < SCALED_W'(limit_reg));
            end
            default: begin
            end
        endcase
    end

    // result register: hold the beat until the sink takes it
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if ((state_reg == S_DONE) && out_free) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if ((state_reg == S_DONE) && out_free) begin
            out_found_reg <= ok_reg;
            out_sbr_reg   <= ok_reg ? best_sbr_reg : '0;
            out_osr_reg   <= ok_reg ? best_osr_reg : '0;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {5'b0, out_osr_reg, out_sbr_reg};
    assign m_tuser  = out_found_reg;

endmodule

### tb/sv/baud_divider_search_tb.sv
// baud_divider_search_tb: self-checking bench for the baud divider search block.
// Sends baud-rate requests under several clock_hz settings and checks every result
// against a divider predictor. Depends on bds_pkg and the baud_divider_search RTL.
module baud_divider_search_tb import bds_pkg::*; ();

    timeunit 1ns;
    timeprecision 1ps;

    // Slowest run is about 580 beats of full searches plus stalls; allow four times that.
    localparam int unsigned CYCLE_LIMIT  = 3_000_000;
    localparam int unsigned LONG_HOLD    = 4000;
    localparam int unsigned HOLD_AT      = 150;
    localparam int unsigned RAND_PHASES  = 10;
    localparam int unsigned PHASE_ITEMS  = 56;
    localparam int unsigned DIR_ROWS     = 21;
    localparam logic [BAUD_W-1:0] BAUD_TOP = '1;
    localparam logic [CLK_W-1:0]  CLK_TOP  = '1;
    localparam int unsigned TOL_PCT      = 3;

    typedef struct packed {
        logic                found;
        logic [SBR_W-1:0]    rate_divisor;
        logic [OSR_W-1:0]    oversample_ratio;
    } divider_pick_t;

    // One directed request: the clock it runs under, the baud rate, and, where the
    // answer is obvious, the typed-in result (otherwise the predictor decides).
    typedef struct {
        logic [CLK_W-1:0]  clock;
        logic [BAUD_W-1:0] baud;
        bit                typed;
        divider_pick_t     pick;
    } baud_row_t;

    localparam divider_pick_t NO_PICK = '0;

    logic        aclk;
    logic        aresetn;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [31:0] cfg_data;
    logic        s_tvalid;
    logic        s_tready;
    logic [31:0] s_tdata;    // [24:0] baud_rate, [31:25] zero
    logic        m_tvalid;
    logic        m_tready;
    logic [23:0] m_tdata;    // [12:0] rate_divisor, [18:13] oversample_ratio, [23:19] zero
    logic        m_tuser;    // [0] found

    baud_divider_search dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_data (cfg_data),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    // Bench copy of the block's single configuration register.
    logic [CLK_W-1:0] clock_hz_now = CLOCK_HZ_RESET;

    divider_pick_t picks_due[$];

    int unsigned errors      = 0;
    int unsigned cycle_count = 0;
    int unsigned sent        = 0;
    int unsigned received    = 0;
    int unsigned n_found     = 0;
    int unsigned n_clock_wr  = 0;
    bit          calm        = 0;   // set for the closing phase: no idling on either side

    // Directed table. Typed rows are the ones readable without arithmetic:
    // zero baud, zero clock, tiny clock, clamped divisors, and the exact tie at 1 Mbaud
    // where ratios 4, 6, 8, 12 and 24 all hit zero error and the last one (24) must win.
    baud_row_t dir_rows [DIR_ROWS] = '{
        '{CLOCK_HZ_RESET, 25'd0,          1'b1, NO_PICK},
        '{CLOCK_HZ_RESET, 25'd1,          1'b1, NO_PICK},
        '{CLOCK_HZ_RESET, BAUD_TOP,       1'b1, NO_PICK},
        '{CLOCK_HZ_RESET, 25'd115200,     1'b0, NO_PICK},
        '{CLOCK_HZ_RESET, 25'd9600,       1'b0, NO_PICK},
        '{CLOCK_HZ_RESET, 25'd1000000,    1'b1, '{1'b1, 13'd1, 6'd24}},
        '{CLOCK_HZ_RESET, 25'd3000000,    1'b0, NO_PICK},
        '{CLOCK_HZ_RESET, 25'h1555555,    1'b0, NO_PICK},
        '{CLOCK_HZ_RESET, 25'h0AAAAAA,    1'b0, NO_PICK},
        '{32'd0,          25'd9600,       1'b1, NO_PICK},
        '{32'd0,          25'd0,          1'b1, NO_PICK},
        '{32'd0,          BAUD_TOP,       1'b1, NO_PICK},
        '{CLK_TOP,        25'd1,          1'b1, NO_PICK},
        '{CLK_TOP,        BAUD_TOP,       1'b0, NO_PICK},
        '{CLK_TOP,        25'd115200,     1'b0, NO_PICK},
        '{CLK_TOP,        25'd300,        1'b0, NO_PICK},
        '{32'd1,          25'd1,          1'b1, NO_PICK},
        '{32'd1,          BAUD_TOP,       1'b1, NO_PICK},
        '{32'd1,          25'd0,          1'b1, NO_PICK},
        '{32'd1843200,    25'd115200,     1'b0, NO_PICK},
        '{CLOCK_HZ_RESET, 25'd400000,     1'b0, NO_PICK}
    };

    // Walk ratios 4..32, round the divisor to nearest (ties up), clamp it, stop on a
    // zero divisor, keep the last ratio with the smallest error, then apply the
    // three-percent tolerance.
    function automatic divider_pick_t pick_dividers(logic [CLK_W-1:0] clk,
                                                    logic [BAUD_W-1:0] baud);
        longint unsigned c, b, den, sbr, actual, err;
        longint unsigned best_err, best_sbr, best_osr, osr;
        bit              tried;
        divider_pick_t   pick;
        c        = clk;
        b        = baud;
        tried    = 0;
        best_err = 0;
        best_sbr = 0;
        best_osr = 0;
        pick     = '0;
        if (b != 0) begin
            for (osr = OSR_FIRST; osr <= OSR_LAST; osr++) begin
                den = b * osr;
                sbr = (2 * c + den) / (2 * den);
                if (sbr > SBR_MAX)
                    sbr = SBR_MAX;
                if (sbr == 0)
                    break;
                actual = c / (osr * sbr);
                err    = (b > actual) ? b - actual : actual - b;
                if (!tried || err <= best_err) begin
                    tried    = 1;
                    best_err = err;
                    best_sbr = sbr;
                    best_osr = osr;
                end
            end
        end
        if (tried) begin
            if (best_err * PCT_SCALE / b <= TOL_PCT) begin
                pick.found            = 1'b1;
                pick.rate_divisor     = best_sbr[SBR_W-1:0];
                pick.oversample_ratio = best_osr[OSR_W-1:0];
            end
        end
        return pick;
    endfunction

    // Random baud rates: mostly rates close to clk/(osr*sbr) so that searches succeed
    // or land near the tolerance edge, plus standard rates, raw noise and tiny values.
    function automatic logic [BAUD_W-1:0] random_baud(logic [CLK_W-1:0] clk);
        longint unsigned b, span;
        int unsigned     osr, sbr, width;
        int unsigned     std_rates [17] = '{300, 1200, 2400, 4800, 9600, 19200, 38400,
                                            57600, 115200, 230400, 460800, 921600,
                                            1000000, 1500000, 2000000, 3000000, 4000000};
        b = 0;
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 9: begin
                osr  = $urandom_range(OSR_FIRST, OSR_LAST);
                sbr  = $urandom_range(0, 1) ? $urandom_range(1, 64)
                                            : $urandom_range(1, SBR_MAX);
                b    = clk / (osr * sbr);
                // narrow jitter mostly stays in tolerance, wide jitter straddles it
                span = b / ($urandom_range(0, 1) ? 60 : 12);
                b    = b - span + $urandom_range(0, int'(2 * span));
                if (b == 0)
                    b = $urandom_range(1, 16);
            end
            4, 5: b = std_rates[$urandom_range(0, 16)];
            6:    b = $urandom & BAUD_TOP;
            7: begin
                width = $urandom_range(1, BAUD_W);
                b     = $urandom & ((32'd1 << width) - 1);
            end
            default: b = $urandom_range(0, 64);
        endcase
        if (b > BAUD_TOP)
            b = BAUD_TOP;
        return b[BAUD_W-1:0];
    endfunction

    // Clock: 8 ns period.
    initial aclk = 1'b0;
    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    // Watchdog.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results still due",
                     cycle_count, picks_due.size());
            $display("baud_divider_search regression: fail");
            $finish;
        end
    end

    // Result side: check each beat against the oldest expectation, and stall in random
    // bursts. Once, after HOLD_AT results, hold off for a long stretch so the block
    // fills up and has to stall its request input.
    initial begin
        divider_pick_t want, got;
        int unsigned   stall_left;
        bit            held;
        m_tready   <= 1'b0;
        stall_left = 0;
        held       = 0;
        @(posedge aclk iff aresetn);
        forever begin
            @(posedge aclk);
            if (m_tvalid && m_tready) begin
                got.found            = m_tuser;
                got.rate_divisor     = m_tdata[12:0];
                got.oversample_ratio = m_tdata[18:13];
                received++;
                if (picks_due.size() == 0) begin
                    $error("result beat with no request outstanding");
                    errors++;
                end else begin
                    want = picks_due.pop_front();
                    if (got.found != want.found) begin
                        $error("found: expected %0d, got %0d", want.found, got.found);
                        errors++;
                    end
                    if (got.rate_divisor != want.rate_divisor) begin
                        $error("rate_divisor: expected %0d, got %0d",
                               want.rate_divisor, got.rate_divisor);
                        errors++;
                    end
                    if (got.oversample_ratio != want.oversample_ratio) begin
                        $error("oversample_ratio: expected %0d, got %0d",
                               want.oversample_ratio, got.oversample_ratio);
                        errors++;
                    end
                end
                if (got.found)
                    n_found++;
            end
            if (!held && received >= HOLD_AT) begin
                held       = 1;
                stall_left = LONG_HOLD;
            end
            if (stall_left > 0) begin
                stall_left--;
                m_tready <= 1'b0;
            end else if (!calm && $urandom_range(0, 7) == 0) begin
                stall_left = $urandom_range(1, 7) - 1;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // Offer one request and hold it until accepted; record its expected result at the
    // accepting edge. Leave tvalid high when no gap follows, so back-to-back beats
    // never see a drop and rise in the same step.
    task automatic send_baud(input logic [BAUD_W-1:0] baud, input bit typed,
                             input divider_pick_t typed_pick);
        int unsigned gap;
        s_tvalid <= 1'b1;
        s_tdata  <= {{(32 - BAUD_W){1'b0}}, baud};
        do
            @(posedge aclk);
        while (!s_tready);
        picks_due.push_back(typed ? typed_pick : pick_dividers(clock_hz_now, baud));
        sent++;
        if (!calm && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 7);
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    // Stop offering and wait until every expected result has come back.
    task automatic drain_requests();
        s_tvalid <= 1'b0;
        while (picks_due.size() != 0)
            @(posedge aclk);
    endtask

    // Reprogram clock_hz, only with the block idle.
    task automatic set_clock(input logic [CLK_W-1:0] value);
        drain_requests();
        repeat (8) @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do
            @(posedge aclk);
        while (!cfg_ready);
        cfg_valid    <= 1'b0;
        clock_hz_now = value;
        n_clock_wr++;
    endtask

    // Stimulus: reset, directed table, then random phases under different clocks.
    initial begin
        logic [CLK_W-1:0] phase_clocks [RAND_PHASES];
        int unsigned      row, phase, item;
        phase_clocks = '{32'd48_000_000, 32'd1, CLK_TOP, 32'd100_000_000, 32'd1_843_200,
                         32'd0, 32'd8_000_000, CLOCK_HZ_RESET, 32'd0, 32'd12_000_000};
        phase_clocks[5] = $urandom;
        phase_clocks[8] = $urandom_range(1_000_000, 200_000_000);

        aresetn   <= 1'b0;
        cfg_valid <= 1'b0;
        cfg_data  <= '0;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed rows; the first ones run on the reset value of clock_hz.
        for (row = 0; row < DIR_ROWS; row++) begin
            if (dir_rows[row].clock != clock_hz_now)
                set_clock(dir_rows[row].clock);
            send_baud(dir_rows[row].baud, dir_rows[row].typed, dir_rows[row].pick);
        end

        for (phase = 0; phase < RAND_PHASES; phase++) begin
            set_clock(phase_clocks[phase]);
            calm = (phase == RAND_PHASES - 1);
            for (item = 0; item < PHASE_ITEMS; item++) begin
                // once, mid-phase, let the pipeline run completely dry before going on
                if (phase == 3 && item == PHASE_ITEMS / 2)
                    drain_requests();
                send_baud(random_baud(clock_hz_now), 1'b0, NO_PICK);
            end
        end

        drain_requests();
        repeat (50) @(posedge aclk);

        $display("sent %0d baud requests under %0d clock_hz writes (0, 1, max and others)",
                 sent, n_clock_wr);
        $display("%0d divider pairs found in tolerance, %0d rejected, %0d mismatches",
                 n_found, received - n_found, errors);
        if (errors == 0) begin
            $display("baud_divider_search regression: pass");
        end else begin
            $display("baud_divider_search regression: fail");
        end
        $finish;
    end

endmodule
